FILE: rtl/core/apt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_pkg
// shared types and constants of the avoid point table
// ----------------------------------------------------------------------------
package apt_pkg;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  localparam logic [1:0] REG_AVOID_RADIUS    = 2'd0;
  localparam logic [1:0] REG_MAX_ENTRIES     = 2'd1;
  localparam logic [1:0] REG_MATCH_TOLERANCE = 2'd2;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [31:0] AVOID_RADIUS_RST    = 32'd65536;
  localparam logic [4:0]  MAX_ENTRIES_RST     = 5'd16;
  localparam logic [15:0] MATCH_TOLERANCE_RST = 16'd66;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_point;
    logic rd_en;
    logic move;
    logic wr_add;
    logic flush;
    logic sel_tol;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic busy;
  } status_t;

endpackage

FILE: rtl/core/apt_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_regs
// configuration registers behind the apb port
// ----------------------------------------------------------------------------
module apt_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [apt_pkg::APB_AW-1:0] paddr,
  input  logic [apt_pkg::APB_DW-1:0] pwdata,
  output logic [apt_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [31:0]                avoid_radius_o,
  output logic [4:0]                 max_entries_o,
  output logic [15:0]                match_tolerance_o
);
  import apt_pkg::*;

  logic [31:0] avoid_radius_q;
  logic [4:0]  max_entries_q;
  logic [15:0] match_tolerance_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avoid_radius_q    <= AVOID_RADIUS_RST;
      max_entries_q     <= MAX_ENTRIES_RST;
      match_tolerance_q <= MATCH_TOLERANCE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_AVOID_RADIUS:    avoid_radius_q    <= pwdata[31:0];
        REG_MAX_ENTRIES:     max_entries_q     <= pwdata[4:0];
        REG_MATCH_TOLERANCE: match_tolerance_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AVOID_RADIUS:    prdata = APB_DW'(avoid_radius_q);
      REG_MAX_ENTRIES:     prdata = APB_DW'(max_entries_q);
      REG_MATCH_TOLERANCE: prdata = APB_DW'(match_tolerance_q);
      default:             prdata = '0;
    endcase
  end

  assign avoid_radius_o    = avoid_radius_q;
  assign max_entries_o     = max_entries_q;
  assign match_tolerance_o = match_tolerance_q;

endmodule

FILE: rtl/core/apt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_datapath
// point store and pipelined manhattan distance compare
// ----------------------------------------------------------------------------
module apt_datapath #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned COORD_WIDTH = 32,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  apt_pkg::cmd_t            cmd_i,
  input  logic [AW-1:0]            rd_addr_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [3*COORD_WIDTH-1:0] point_i,
  input  logic [31:0]              avoid_radius_i,
  input  logic [15:0]              match_tolerance_i,
  output apt_pkg::status_t         status_o,
  output logic [AW-1:0]            hit_idx_o
);
  import apt_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned PW    = 3 * CW;
  localparam int unsigned SUM_W = CW + 2;
  localparam int unsigned CMP_W = (SUM_W > 32) ? SUM_W : 32;

  logic [PW-1:0]    mem [CAPACITY];
  logic [PW-1:0]    point_q;
  logic [PW-1:0]    rd_data_q;
  logic             rd_v_q, ab_v_q, sm_v_q, mv_v_q;
  logic [AW-1:0]    rd_idx_q, ab_idx_q, sm_idx_q, mv_addr_q;
  logic signed [CW:0] diff [3];
  logic signed [CW:0] neg [3];
  logic [CW-1:0]    abs_d [3];
  logic [CW-1:0]    ab_q [3];
  logic [SUM_W-1:0] sum_d, sum_q;
  logic [CMP_W-1:0] thr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_point) begin
      point_q <= point_i;
    end
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_add) begin
      mem[wr_addr_i] <= point_q;
    end else if (mv_v_q) begin
      mem[mv_addr_q] <= rd_data_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
      ab_v_q <= 1'b0;
      sm_v_q <= 1'b0;
      mv_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.rd_en & ~cmd_i.move & ~cmd_i.flush;
      ab_v_q <= rd_v_q & ~cmd_i.flush;
      sm_v_q <= ab_v_q & ~cmd_i.flush;
      mv_v_q <= cmd_i.rd_en & cmd_i.move;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = $signed({rd_data_q[k*CW+CW-1], rd_data_q[k*CW +: CW]})
              - $signed({point_q[k*CW+CW-1], point_q[k*CW +: CW]});
      neg[k]   = -diff[k];
      abs_d[k] = diff[k][CW] ? neg[k][CW-1:0] : diff[k][CW-1:0];
    end
  end

  assign sum_d = SUM_W'(ab_q[0]) + SUM_W'(ab_q[1]) + SUM_W'(ab_q[2]);

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_addr_i;
    mv_addr_q <= rd_addr_i - AW'(1);
    ab_idx_q  <= rd_idx_q;
    sm_idx_q  <= ab_idx_q;
    for (int k = 0; k < 3; k++) begin
      ab_q[k] <= abs_d[k];
    end
    sum_q <= sum_d;
  end

  assign thr = cmd_i.sel_tol ? CMP_W'(match_tolerance_i) : CMP_W'(avoid_radius_i);

  assign status_o.hit  = sm_v_q && (CMP_W'(sum_q) < thr);
  assign status_o.busy = rd_v_q | ab_v_q | sm_v_q;
  assign hit_idx_o     = sm_idx_q;

endmodule

FILE: rtl/core/apt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apt_ctrl
// command sequencer, fill count and result register
// ----------------------------------------------------------------------------
module apt_ctrl #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  apt_pkg::op_e      s_op_i,
  output logic              s_ready_o,
  input  logic [4:0]        max_entries_i,
  output apt_pkg::cmd_t     cmd_o,
  output logic [AW-1:0]     rd_addr_o,
  output logic [AW-1:0]     wr_addr_o,
  input  apt_pkg::status_t  status_i,
  input  logic [AW-1:0]     hit_idx_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic              avoided_o,
  output logic              removed_o,
  output logic              flushed_o,
  output logic [CNT_W-1:0]  count_o
);
  import apt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  op_e              op_q, op_d;
  logic             avoid_q, avoid_d, rem_q, rem_d, flush_q, flush_d;
  logic             m_valid_q, m_valid_d;
  logic             out_avoid_q, out_rem_q, out_flush_q;
  logic [CNT_W-1:0] out_count_q;
  logic             load_out;
  logic             add_full;
  logic [CNT_W-1:0] limit;

  // zero counts as one, anything above the store depth as the depth
  always_comb begin
    if (max_entries_i == 5'd0) begin
      limit = CNT_W'(1);
    end else if (32'(max_entries_i) > 32'(CAPACITY)) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = CNT_W'(max_entries_i);
    end
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    op_d      = op_q;
    avoid_d   = avoid_q;
    rem_d     = rem_q;
    flush_d   = flush_q;
    m_valid_d = m_valid_q;
    load_out  = 1'b0;
    add_full  = 1'b0;
    s_ready_o = 1'b0;
    rd_addr_o = '0;
    wr_addr_o = '0;
    cmd_o         = '0;
    cmd_o.sel_tol = (op_q == OP_REMOVE);

    if (m_valid_q && m_ready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_point = 1'b1;
          op_d    = s_op_i;
          avoid_d = 1'b0;
          rem_d   = 1'b0;
          flush_d = 1'b0;
          idx_d   = '0;
          unique case (s_op_i) inside
            OP_QUERY, OP_REMOVE: state_d = ST_SCAN;
            OP_ADD:              state_d = ST_ADD;
            OP_CLEAR: begin
              fill_d  = '0;
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          cmd_o.flush = 1'b1;
          if (op_q == OP_QUERY) begin
            avoid_d = 1'b1;
            state_d = ST_RESP;
          end else begin
            rem_d   = 1'b1;
            idx_d   = CNT_W'(hit_idx_i) + CNT_W'(1);
            state_d = ST_SHIFT;
          end
        end else if (idx_q == fill_q) begin
          if (!status_i.busy) begin
            state_d = ST_RESP;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = idx_q[AW-1:0];
          idx_d       = idx_q + CNT_W'(1);
        end
      end
      ST_SHIFT: begin
        // close the gap, one entry moved down per cycle
        if (idx_q < fill_q) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.move  = 1'b1;
          rd_addr_o   = idx_q[AW-1:0];
          idx_d       = idx_q + CNT_W'(1);
        end else begin
          fill_d  = fill_q - CNT_W'(1);
          state_d = ST_RESP;
        end
      end
      ST_ADD: begin
        add_full     = (fill_q >= limit);
        flush_d      = add_full;
        cmd_o.wr_add = 1'b1;
        wr_addr_o    = add_full ? '0 : fill_q[AW-1:0];
        fill_d       = add_full ? CNT_W'(1) : fill_q + CNT_W'(1);
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (!m_valid_q || m_ready_i) begin
          load_out  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    avoid_q <= avoid_d;
    rem_q   <= rem_d;
    flush_q <= flush_d;
    if (load_out) begin
      out_avoid_q <= avoid_q;
      out_rem_q   <= rem_q;
      out_flush_q <= flush_q;
      out_count_q <= fill_q;
    end
  end

  assign m_valid_o = m_valid_q;
  assign avoided_o = out_avoid_q;
  assign removed_o = out_rem_q;
  assign flushed_o = out_flush_q;
  assign count_o   = out_count_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(CAPACITY))
    else $error("fill count above store depth");

  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> $onehot0({out_avoid_q, out_rem_q, out_flush_q}))
    else $error("more than one result flag set");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !status_i.busy)
    else $error("compare pipe still busy while idle");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && s_valid_i && s_op_i == OP_CLEAR) |=> (fill_q == '0))
    else $error("clear left entries behind");

  a_add_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |=> (fill_q != '0))
    else $error("add left the table empty");

endmodule

FILE: rtl/core/avoid_point_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avoid_point_table_top
// bounded table of 3d points with query, add, remove and clear requests
// ----------------------------------------------------------------------------
// One request is handled at a time, and the input is ready only while no
// request is in progress. Query and remove scan the stored points through a
// single read port of the point store, one point per cycle. A registered
// distance and compare pipe follows, and the scan waits for it to drain.
// A query stops at the first matching slot, and so does a remove; an empty
// table skips the scan. After a match in slot h of n stored points, a remove
// moves the n - h - 1 later points down one slot, one point per cycle, and
// then lowers the fill count. The result is held in an output register, so
// a finished request does not wait on the next one's input. Only a result
// that is still unread when the next request finishes holds that request
// back.
// ----------------------------------------------------------------------------
module avoid_point_table_top #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned COORD_WIDTH = 32,
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1),
  localparam int unsigned IN_W   = ((3 * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W  = ((3 + CNT_W + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [IN_W-1:0]            s_axis_tdata,   // px, py, pz
  input  logic [1:0]                 s_axis_tuser,   // op
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata,   // is_avoided, removed,
                                                     // was_flushed, entry_count
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [apt_pkg::APB_AW-1:0] paddr,
  input  logic [apt_pkg::APB_DW-1:0] pwdata,
  output logic [apt_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import apt_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [31:0]      avoid_radius;
  logic [4:0]       max_entries;
  logic [15:0]      match_tolerance;
  cmd_t             cmd;
  status_t          status;
  logic [AW-1:0]    rd_addr, wr_addr, hit_idx;
  logic             avoided, removed, flushed;
  logic [CNT_W-1:0] count;
  op_e              op;

  assign op = op_e'(s_axis_tuser);

  apt_regs u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .avoid_radius_o    (avoid_radius),
    .max_entries_o     (max_entries),
    .match_tolerance_o (match_tolerance)
  );

  apt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_op_i        (op),
    .s_ready_o     (s_axis_tready),
    .max_entries_i (max_entries),
    .cmd_o         (cmd),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .status_i      (status),
    .hit_idx_i     (hit_idx),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .avoided_o     (avoided),
    .removed_o     (removed),
    .flushed_o     (flushed),
    .count_o       (count)
  );

  apt_datapath #(
    .CAPACITY    (CAPACITY),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .rd_addr_i         (rd_addr),
    .wr_addr_i         (wr_addr),
    .point_i           (s_axis_tdata[3*COORD_WIDTH-1:0]),
    .avoid_radius_i    (avoid_radius),
    .match_tolerance_i (match_tolerance),
    .status_o          (status),
    .hit_idx_o         (hit_idx)
  );

  assign m_axis_tdata = OUT_W'({count, flushed, removed, avoided});

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the avoid point table
// ----------------------------------------------------------------------------
// Drives query, add, remove and clear requests over the stream input and
// predicts every result from a shadow copy of the point table and of the
// three registers. Directed requests cover the coordinate extremes, the
// thresholds and the empty and full table. Random traffic mostly aims at
// stored points so that hits, removes and flushes happen often. Registers
// are rewritten between phases, extremes and clamped values included, and
// both stream sides idle and stall at changing rates.
// ----------------------------------------------------------------------------
module tb_top;
  import apt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam logic [1:0]  REG_SPARE   = 2'd3;
  localparam logic [31:0] COORD_MAX   = 32'h7fff_ffff;
  localparam logic [31:0] COORD_MIN   = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } point_t;

  typedef struct packed {
    logic [4:0] entry_count;
    logic       was_flushed;
    logic       removed;
    logic       is_avoided;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_QUERY;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic        pready;

  // shadow table and registers
  point_t      stored_pts [TABLE_DEPTH];
  int unsigned stored_cnt = 0;
  logic [31:0] radius_reg = AVOID_RADIUS_RST;
  logic [4:0]  max_reg = MAX_ENTRIES_RST;
  logic [15:0] tol_reg = MATCH_TOLERANCE_RST;

  result_t pending_results [$];
  int      err_cnt = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  avoid_point_table_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint unsigned abs_diff(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return (d < 0) ? longint'(-d) : d;
  endfunction

  function automatic longint unsigned l1_dist(point_t a, point_t b);
    return abs_diff(a.x, b.x) + abs_diff(a.y, b.y) + abs_diff(a.z, b.z);
  endfunction

  function automatic result_t predict_table_op(op_e op, point_t pt);
    result_t     res;
    int unsigned lim;
    res = '0;
    case (op)
      OP_QUERY: begin
        for (int i = 0; i < stored_cnt; i++) begin
          if (l1_dist(stored_pts[i], pt) < longint'(radius_reg)) begin
            res.is_avoided = 1'b1;
            break;
          end
        end
      end
      OP_ADD: begin
        lim = (max_reg == 0) ? 1 : (max_reg > TABLE_DEPTH) ? TABLE_DEPTH : max_reg;
        if (stored_cnt >= lim) begin
          stored_cnt = 0;
          res.was_flushed = 1'b1;
        end
        stored_pts[stored_cnt] = pt;
        stored_cnt++;
      end
      OP_REMOVE: begin
        for (int i = 0; i < stored_cnt; i++) begin
          if (l1_dist(stored_pts[i], pt) < longint'(tol_reg)) begin
            for (int j = i; j + 1 < stored_cnt; j++) stored_pts[j] = stored_pts[j + 1];
            stored_cnt--;
            res.removed = 1'b1;
            break;
          end
        end
      end
      default: stored_cnt = 0;
    endcase
    res.entry_count = stored_cnt[4:0];
    return res;
  endfunction

  // one request on the stream input, predicted when accepted
  task automatic send_request(op_e op, point_t pt);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pt;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), predict_table_op(op, pt));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_AVOID_RADIUS:    radius_reg = val;
      REG_MAX_ENTRIES:     max_reg = val[4:0];
      REG_MATCH_TOLERANCE: tol_reg = val[15:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check(logic [1:0] idx, logic [31:0] exp_val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== exp_val) begin
      $error("register %0d: expected %h, got %h", idx, exp_val, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [31:0] radius, logic [4:0] max_e, logic [15:0] tol);
    wait_idle();
    apb_write(REG_AVOID_RADIUS, radius);
    apb_write(REG_MAX_ENTRIES, {27'd0, max_e});
    apb_write(REG_MATCH_TOLERANCE, {16'd0, tol});
  endtask

  task automatic test_directed();
    send_request(OP_QUERY, '{z: 0, y: 0, x: 0});
    send_request(OP_REMOVE, '{z: 0, y: 0, x: 0});
    send_request(OP_ADD, '{z: 0, y: 0, x: 0});
    send_request(OP_ADD, '{z: COORD_MAX, y: COORD_MAX, x: COORD_MAX});
    send_request(OP_ADD, '{z: COORD_MIN, y: COORD_MIN, x: COORD_MIN});
    send_request(OP_QUERY, '{z: 0, y: 0, x: 32'd65535});
    send_request(OP_QUERY, '{z: 0, y: 0, x: 32'd65536});
    send_request(OP_QUERY, '{z: COORD_MAX, y: COORD_MAX, x: COORD_MAX - 1});
    send_request(OP_QUERY, '{z: COORD_MAX, y: COORD_MIN, x: COORD_MIN});
    send_request(OP_REMOVE, '{z: COORD_MIN, y: COORD_MIN, x: COORD_MIN + 65});
    send_request(OP_REMOVE, '{z: 0, y: 32'd1, x: 32'd65});
    send_request(OP_REMOVE, '{z: 0, y: 0, x: 32'd65});
    send_request(OP_QUERY, '{z: COORD_MAX - 65535, y: COORD_MAX, x: COORD_MAX});
    send_request(OP_QUERY, '{z: 32'hffff_ffff, y: 32'hffff_ffff, x: 32'hffff_ffff});
    send_request(OP_CLEAR, '{z: 32'hffff_ffff, y: 32'hffff_ffff, x: 32'hffff_ffff});
    send_request(OP_QUERY, '{z: 0, y: 0, x: 0});
    send_request(OP_REMOVE, '{z: 0, y: 0, x: 0});
  endtask

  // max_entries zero, both radius extremes, both tolerance extremes
  task automatic test_config_limits();
    set_config(32'd0, 5'd0, 16'd0);
    send_request(OP_ADD, '{z: 0, y: 0, x: 0});
    send_request(OP_ADD, '{z: COORD_MAX, y: COORD_MAX, x: COORD_MAX});
    send_request(OP_QUERY, '{z: COORD_MAX, y: COORD_MAX, x: COORD_MAX});
    send_request(OP_REMOVE, '{z: COORD_MAX, y: COORD_MAX, x: COORD_MAX});
    set_config(32'hffff_ffff, 5'd1, 16'hffff);
    send_request(OP_QUERY, '{z: COORD_MAX, y: COORD_MAX, x: COORD_MIN});
    send_request(OP_QUERY, '{z: COORD_MAX, y: COORD_MAX, x: COORD_MIN + 1});
    send_request(OP_ADD, '{z: COORD_MIN, y: 0, x: 32'd7});
    send_request(OP_REMOVE, '{z: COORD_MIN, y: 32'd65534, x: 32'd7});
  endtask

  task automatic test_register_access();
    wait_idle();
    apb_check(REG_AVOID_RADIUS, radius_reg);
    apb_check(REG_MAX_ENTRIES, {27'd0, max_reg});
    apb_check(REG_MATCH_TOLERANCE, {16'd0, tol_reg});
    apb_write(REG_AVOID_RADIUS, 32'ha5a5_5a5a);
    apb_write(REG_MAX_ENTRIES, 32'hffff_ffe7);
    apb_write(REG_MATCH_TOLERANCE, 32'h1234_9876);
    apb_write(REG_SPARE, 32'hffff_ffff);
    apb_check(REG_AVOID_RADIUS, radius_reg);
    apb_check(REG_MAX_ENTRIES, {27'd0, max_reg});
    apb_check(REG_MATCH_TOLERANCE, {16'd0, tol_reg});
  endtask

  function automatic logic [31:0] jitter(logic [31:0] v, logic [31:0] span);
    case ($urandom_range(2))
      0: return v;
      1: return v + $urandom_range(span);
      default: return v - $urandom_range(span);
    endcase
  endfunction

  // requests mostly aimed near stored points, the rest anywhere
  task automatic test_random_traffic(int n_req, int idle_pct, int stall_pct);
    op_e         op;
    point_t      pt;
    logic [31:0] scale;
    logic [31:0] span;
    logic [31:0] raw [3];
    int          r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_req) begin
      r  = $urandom_range(99);
      op = (r < 35) ? OP_QUERY : (r < 65) ? OP_ADD : (r < 94) ? OP_REMOVE : OP_CLEAR;
      scale = (op == OP_REMOVE) ? {16'd0, tol_reg} : radius_reg;
      span  = (scale > 32'h0100_0000) ? 32'h0080_0000 : scale / 2 + 1;
      if (stored_cnt != 0 && $urandom_range(99) < 75) begin
        pt   = stored_pts[$urandom_range(stored_cnt - 1)];
        pt.x = jitter(pt.x, span);
        pt.y = jitter(pt.y, span);
        pt.z = jitter(pt.z, span);
      end else begin
        for (int k = 0; k < 3; k++) begin
          case ($urandom_range(9))
            0: raw[k] = COORD_MAX;
            1: raw[k] = COORD_MIN;
            2: raw[k] = 32'd0;
            3: raw[k] = 32'hffff_ffff;
            default: raw[k] = $urandom;
          endcase
        end
        pt = '{z: raw[2], y: raw[1], x: raw[0]};
      end
      send_request(op, pt);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    result_t exp_res;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        err_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (got.is_avoided !== exp_res.is_avoided) begin
          $error("is_avoided: expected %0d, got %0d", exp_res.is_avoided, got.is_avoided);
          err_cnt++;
        end
        if (got.removed !== exp_res.removed) begin
          $error("removed: expected %0d, got %0d", exp_res.removed, got.removed);
          err_cnt++;
        end
        if (got.was_flushed !== exp_res.was_flushed) begin
          $error("was_flushed: expected %0d, got %0d", exp_res.was_flushed, got.was_flushed);
          err_cnt++;
        end
        if (got.entry_count !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_res.entry_count, got.entry_count);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_config_limits();
    test_register_access();

    set_config(32'd65536, 5'd16, 16'd66);
    test_random_traffic(130, 0, 0);
    set_config(32'h0010_0000, 5'd4, 16'hffff);
    test_random_traffic(130, 56, 0);
    set_config(32'd0, 5'd1, 16'd0);
    test_random_traffic(130, 0, 56);
    set_config(32'hffff_ffff, 5'd31, 16'd1000);
    test_random_traffic(130, 31, 31);
    set_config($urandom, 5'd0, $urandom);
    test_random_traffic(130, 0, 0);
    set_config($urandom_range(32'h0004_0000), 5'd17, 16'hffff);
    test_random_traffic(130, 56, 0);
    set_config($urandom, $urandom_range(1, 16), $urandom);
    test_random_traffic(130, 0, 56);
    set_config($urandom, $urandom_range(31), $urandom);
    test_random_traffic(130, 31, 31);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: avoid_point_table_top.f
rtl/core/apt_pkg.sv
rtl/core/apt_regs.sv
rtl/core/apt_datapath.sv
rtl/core/apt_ctrl.sv
rtl/core/avoid_point_table_top.sv
test/tb_top.sv
